### sv/hall_sensor_angle_velocity_defines.svh
// ----------------------------------------------------------------------------
// Hall decoder assertion macros
// Shared concurrent assertion forms for the Hall decoder checker.
// ----------------------------------------------------------------------------
`ifndef HALL_SENSOR_ANGLE_VELOCITY_DEFINES_SVH
`define HALL_SENSOR_ANGLE_VELOCITY_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent
`define HSAV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hall decoder check failed");

// Consequent must hold in the same cycle as the antecedent
`define HSAV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hall decoder check failed");

`endif

### sv/hsav_pkg.sv
// ----------------------------------------------------------------------------
// Hall decoder package
// Types, constants and the sector table of the Hall position/speed decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsav_pkg;

  // Divider widths: dividend covers two pi * 1e6 at the finest fraction
  localparam int DIV_W     = 48;
  localparam int DVS_W     = 32;
  localparam int DIV_CNT_W = 6;

  localparam int    TP_W              = 27;
  localparam longint USEC_PER_SEC     = 1000000;
  localparam logic [31:0] INTERP_MAX_PERIOD = 32'd50000;
  localparam logic [31:0] INTERP_MAX_AGE    = 32'd500000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT_GO,
    ST_TOT_WT,
    ST_ANG_GO,
    ST_ANG_WT,
    ST_I1_GO,
    ST_I1_WT,
    ST_I2_GO,
    ST_I2_WT,
    ST_VEL,
    ST_V1_GO,
    ST_V1_WT,
    ST_V2_GO,
    ST_V2_WT,
    ST_OUT
  } hsav_state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // Hall code to sector; codes 0 and 7 are invalid and map to -1
  function automatic logic signed [3:0] sector_map(input logic [2:0] hall);
    logic signed [3:0] s;
    unique case (hall)
      3'd1:    s = 4'sd0;
      3'd2:    s = 4'sd4;
      3'd3:    s = 4'sd5;
      3'd4:    s = 4'sd2;
      3'd5:    s = 4'sd1;
      3'd6:    s = 4'sd3;
      default: s = -4'sd1;
    endcase
    return s;
  endfunction

endpackage

### sv/hsav_div.sv
// ----------------------------------------------------------------------------
// Hall decoder divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsav_div import hsav_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DVS_W:0]       shifted;
  logic [DVS_W:0]       trial;
  logic                 fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = ~trial[DVS_W];

  // Control: load on start, count down the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

### sv/hall_sensor_angle_velocity.sv
// ----------------------------------------------------------------------------
// Hall sensor angle and velocity decoder
// Decodes Hall edges into direction, period and turns; on update requests
// derives angle, full turns and interpolated angle, and on every request velocity.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  in       | in_valid_i / in_ready_o | func_i, hall_bits_i, now_us_i
//  out      | out_valid_o/out_ready_i | shaft_angle_o .. edge_taken_o
//  cfg      | cfg_we_i                | cfg_wdata_i (pole pairs)
//
//  Each division on the shared divider is a start followed by one quotient
//  bit per dividend bit, with the done pulse raised as the last bit shifts in.
//  An edge-only request runs up to two divisions; an update request runs
//  up to six. in_ready_o is high only when idle, from the cycle after the
//  result loads; a result still waiting in the output register stalls the
//  load.
//  Reset is asynchronous, active low; pole pairs reset to one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hall_sensor_angle_velocity import hsav_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [2:0]         hall_bits_i,
  input  logic [31:0]        now_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] shaft_angle_o,
  output logic signed [31:0] turn_angle_o,
  output logic signed [31:0] velocity_o,
  output logic signed [31:0] full_turns_o,
  output logic               rotating_ccw_o,
  output logic               edge_taken_o
);

  localparam longint TwoPiL = (((64'sd210828714 >>> (24 - FRAC_BITS)) + 1) >>> 1);
  localparam logic [TP_W-1:0]  TWO_PI  = TP_W'(TwoPiL);
  localparam logic [DIV_W-1:0] VEL_NUM = DIV_W'(TwoPiL * USEC_PER_SEC);

  hsav_state_e state_q, state_d;

  // Edge tracking state
  logic [6:0]           pp_q;
  logic [2:0]           last_hall_q;
  logic signed [3:0]    sector_q;
  logic [31:0]          eturns_q;
  logic signed [1:0]    dir_now_q;
  logic signed [1:0]    dir_before_q;
  logic [TIME_BITS-1:0] edge_time_q;
  logic [TIME_BITS-1:0] period_q;
  logic                 fresh_q;

  // Work registers
  logic [TIME_BITS-1:0] now_q;
  logic                 taken_q;
  logic                 neg_q, neg_d;
  logic [9:0]           rmag_q, rmag_d;
  logic [DIV_W-1:0]     tmp_q, tmp_d;
  logic [31:0]          angle_q, angle_d;
  logic [31:0]          turns_q, turns_d;
  logic [31:0]          vel_q, vel_d;
  logic                 fresh_clr;
  logic                 out_load;

  // Output registers
  logic        out_valid_q;
  logic [31:0] shaft_q, tangle_q, velo_q, fturns_q;
  logic        ccw_q, etaken_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 in_acc;
  logic                 hall_chg;
  logic signed [3:0]    ns;
  logic signed [4:0]    diff;
  logic signed [1:0]    dir_new;
  logic [31:0]          eturns_new;
  logic [TIME_BITS-1:0] now_m;
  logic [6:0]           pp_eff;
  logic [9:0]           cpr;
  logic [TIME_BITS-1:0] dt;
  logic [31:0]          dt32, per32;
  logic                 interp_ok, stale;
  logic signed [35:0]   t36, total;
  logic                 tot_neg;
  logic [35:0]          tot_mag;
  logic [36:0]          ang_prod;
  logic [45:0]          i_prod;
  logic [31:0]          qlo;

  assign in_acc = in_valid_i & in_ready_o;
  assign now_m  = now_us_i[TIME_BITS-1:0];

  // Counts per turn, zero pole pairs treated as one
  assign pp_eff = (pp_q == 7'd0) ? 7'd1 : pp_q;
  assign cpr    = ({3'b0, pp_eff} << 2) + ({3'b0, pp_eff} << 1);

  // Edge step: sector, direction and turn wrap
  always_comb begin
    hall_chg   = hall_bits_i != last_hall_q;
    ns         = sector_map(hall_bits_i);
    diff       = {ns[3], ns} - {sector_q[3], sector_q};
    eturns_new = eturns_q;
    if (diff > 5'sd3) begin
      dir_new    = -2'sd1;
      eturns_new = eturns_q - 32'd1;
    end else if (diff < -5'sd3) begin
      dir_new    = 2'sd1;
      eturns_new = eturns_q + 32'd1;
    end else begin
      dir_new = (ns > sector_q) ? 2'sd1 : -2'sd1;
    end
  end

  // Timing checks for interpolation and staleness
  assign dt        = now_q - edge_time_q;
  assign dt32      = 32'(dt);
  assign per32     = 32'(period_q);
  assign interp_ok = (per32 < INTERP_MAX_PERIOD) && (dt32 < INTERP_MAX_AGE) &&
                     (per32 != 32'd0);
  assign stale     = {1'b0, dt} > {period_q, 1'b0};

  // Total sector count and its magnitude
  assign t36     = {{4{eturns_q[31]}}, eturns_q};
  assign total   = (t36 <<< 2) + (t36 <<< 1) + 36'(sector_q);
  assign tot_neg = total[35];
  assign tot_mag = tot_neg ? 36'(-total) : 36'(total);

  assign ang_prod = rmag_q * TWO_PI;
  assign i_prod   = dt32[18:0] * TWO_PI;
  assign qlo      = div_rsp.quo[31:0];

  // Sequencer: next state, divider operands and work register updates
  always_comb begin
    state_d   = state_q;
    div_req   = '0;
    neg_d     = neg_q;
    rmag_d    = rmag_q;
    tmp_d     = tmp_q;
    angle_d   = angle_q;
    turns_d   = turns_q;
    vel_d     = vel_q;
    fresh_clr = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = func_i ? ST_TOT_GO : ST_VEL;
      end
      ST_TOT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(tot_mag);
        div_req.divisor  = DVS_W'(cpr);
        state_d          = ST_TOT_WT;
      end
      ST_TOT_WT: begin
        if (div_rsp.done) begin
          turns_d = tot_neg ? -qlo : qlo;
          neg_d   = tot_neg;
          rmag_d  = div_rsp.rem[9:0];
          state_d = ST_ANG_GO;
        end
      end
      ST_ANG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(ang_prod);
        div_req.divisor  = DVS_W'(cpr);
        state_d          = ST_ANG_WT;
      end
      ST_ANG_WT: begin
        if (div_rsp.done) begin
          angle_d = neg_q ? -qlo : qlo;
          if (fresh_q) begin
            fresh_clr = 1'b1;
            state_d   = ST_VEL;
          end else if (interp_ok) begin
            if (dt32 < per32) begin
              state_d = ST_I1_GO;
            end else begin
              tmp_d   = DIV_W'(TWO_PI);
              state_d = ST_I2_GO;
            end
          end else begin
            state_d = ST_VEL;
          end
        end
      end
      ST_I1_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(i_prod);
        div_req.divisor  = per32;
        state_d          = ST_I1_WT;
      end
      ST_I1_WT: begin
        if (div_rsp.done) begin
          tmp_d   = div_rsp.quo;
          state_d = ST_I2_GO;
        end
      end
      ST_I2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = tmp_q;
        div_req.divisor  = DVS_W'(cpr);
        state_d          = ST_I2_WT;
      end
      ST_I2_WT: begin
        if (div_rsp.done) begin
          if (dir_now_q == 2'sd1)       angle_d = angle_q + qlo;
          else if (dir_now_q == -2'sd1) angle_d = angle_q - qlo;
          state_d = ST_VEL;
        end
      end
      ST_VEL: begin
        if (period_q == '0 || stale) begin
          vel_d   = 32'd0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_V1_GO;
        end
      end
      ST_V1_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = VEL_NUM;
        div_req.divisor  = per32;
        state_d          = ST_V1_WT;
      end
      ST_V1_WT: begin
        if (div_rsp.done) begin
          tmp_d   = div_rsp.quo;
          state_d = ST_V2_GO;
        end
      end
      ST_V2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = tmp_q;
        div_req.divisor  = DVS_W'(cpr);
        state_d          = ST_V2_WT;
      end
      ST_V2_WT: begin
        if (div_rsp.done) begin
          // Apply direction and saturate to 32 bits signed
          if (dir_now_q == 2'sd1) begin
            vel_d = (div_rsp.quo > DIV_W'(32'h7fffffff)) ? 32'h7fffffff : qlo;
          end else if (dir_now_q == -2'sd1) begin
            vel_d = (div_rsp.quo > DIV_W'(32'h80000000)) ? 32'h80000000 : -qlo;
          end else begin
            vel_d = 32'd0;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Configuration, edge tracking state and the angle and turn work registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q         <= 7'd1;
      last_hall_q  <= '0;
      sector_q     <= '0;
      eturns_q     <= '0;
      dir_now_q    <= '0;
      dir_before_q <= '0;
      edge_time_q  <= '0;
      period_q     <= '0;
      fresh_q      <= 1'b0;
      angle_q      <= '0;
      turns_q      <= '0;
    end else begin
      if (cfg_we_i) pp_q <= cfg_wdata_i;
      angle_q <= angle_d;
      turns_q <= turns_d;
      if (fresh_clr) fresh_q <= 1'b0;
      if (in_acc && hall_chg) begin
        last_hall_q  <= hall_bits_i;
        sector_q     <= ns;
        eturns_q     <= eturns_new;
        dir_now_q    <= dir_new;
        dir_before_q <= dir_new;
        period_q     <= (dir_new == dir_before_q) ? now_m - edge_time_q : '0;
        edge_time_q  <= now_m;
        fresh_q      <= 1'b1;
      end
    end
  end

  // Request capture and scratch registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q   <= now_m;
      taken_q <= hall_chg;
    end
    neg_q  <= neg_d;
    rmag_q <= rmag_d;
    tmp_q  <= tmp_d;
    vel_q  <= vel_d;
  end

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      shaft_q  <= 32'(turns_q * 32'(TWO_PI)) + angle_q;
      tangle_q <= angle_q;
      velo_q   <= vel_q;
      fturns_q <= turns_q;
      ccw_q    <= dir_now_q == -2'sd1;
      etaken_q <= taken_q;
    end
  end

  hsav_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign shaft_angle_o  = shaft_q;
  assign turn_angle_o   = tangle_q;
  assign velocity_o     = velo_q;
  assign full_turns_o   = fturns_q;
  assign rotating_ccw_o = ccw_q;
  assign edge_taken_o   = etaken_q;

endmodule

### sv/hsav_checker.sv
// ----------------------------------------------------------------------------
// Hall decoder port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hall_sensor_angle_velocity_defines.svh"

module hsav_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [6:0]         cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               func_i,
  input logic [2:0]         hall_bits_i,
  input logic [31:0]        now_us_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] shaft_angle_o,
  input logic signed [31:0] turn_angle_o,
  input logic signed [31:0] velocity_o,
  input logic signed [31:0] full_turns_o,
  input logic               rotating_ccw_o,
  input logic               edge_taken_o
);

  // A stalled result stays put
  `HSAV_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(velocity_o))

  // The block is busy right after taking a request
  `HSAV_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)

  // Nonzero velocity carries the sign of the reported direction
  `HSAV_ASSERT_NOW(a_vel_sign, out_valid_o && velocity_o != 32'sd0, velocity_o[31] == rotating_ccw_o)

endmodule

bind hall_sensor_angle_velocity hsav_checker u_hsav_checker (.*);
